@@ design/hkrt_pkg.sv @@
// hkrt_pkg: shared types and constants of the keyboard report tracker
// no dependencies; imported by the interfaces, the slot cell and the top level
package hkrt_pkg;

  localparam int unsigned KEY_W        = 8;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned HELD_W       = 3;
  localparam int unsigned REPORT_SLOTS = 6;

  // modifier keys live at 0xE0..0xE7
  localparam logic [KEY_W-1:0] MOD_MASK = 8'hF8;
  localparam logic [KEY_W-1:0] MOD_BASE = 8'hE0;
  localparam logic [KEY_W-1:0] MOD_BIT  = 8'h07;

  typedef enum logic [MODE_W-1:0] {
    MODE_DOWN = 2'd0,
    MODE_UP   = 2'd1,
    MODE_NOP  = 2'd2
  } hkrt_mode_e;

  // per-cycle control broadcast to every slot cell
  typedef struct packed {
    logic cmp;      // compare phase: cells latch their match flag
    logic commit;   // update phase, report register free
    logic press;    // non-modifier, non-zero key down
    logic rel;      // non-modifier, non-zero key up
    logic any_hit;  // some cell matched the key
  } hkrt_ctl_t;

endpackage

@@ design/hkrt_if.sv @@
// hkrt_evt_if / hkrt_rpt_if: valid-ready channels for key events and reports
// depends on hkrt_pkg for field widths
interface hkrt_evt_if;
  import hkrt_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  keycode;
  modport source (output valid, mode, keycode, input ready);
  modport sink   (input valid, mode, keycode, output ready);
endinterface

interface hkrt_rpt_if;
  import hkrt_pkg::*;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  modifier_bits;
  logic [KEY_W-1:0]  slot0_code;
  logic [KEY_W-1:0]  slot1_code;
  logic [KEY_W-1:0]  slot2_code;
  logic [KEY_W-1:0]  slot3_code;
  logic [KEY_W-1:0]  slot4_code;
  logic [KEY_W-1:0]  slot5_code;
  logic [HELD_W-1:0] held_count;
  modport source (output valid, modifier_bits, slot0_code, slot1_code, slot2_code,
                  slot3_code, slot4_code, slot5_code, held_count, input ready);
  modport sink   (input valid, modifier_bits, slot0_code, slot1_code, slot2_code,
                  slot3_code, slot4_code, slot5_code, held_count, output ready);
endinterface

@@ design/hkrt_cell.sv @@
// hkrt_cell: one key slot of the report list, with match, shift and append logic
// depends on hkrt_pkg; chained by hkrt top level
module hkrt_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hkrt_pkg::hkrt_ctl_t      ctl_i,
  input  logic [hkrt_pkg::KEY_W-1:0] key_i,
  input  logic [hkrt_pkg::KEY_W-1:0] next_code_i,
  input  logic                     shift_i,
  input  logic                     empty_seen_i,
  output logic [hkrt_pkg::KEY_W-1:0] code_o,
  output logic [hkrt_pkg::KEY_W-1:0] code_d_o,
  output logic                     shift_o,
  output logic                     empty_seen_o
);
  import hkrt_pkg::*;

  logic [KEY_W-1:0] code_q, code_d;
  logic             hit_q;
  logic             is_empty;

  assign is_empty     = (code_q == '0);
  // release shifts from the matching slot upward
  assign shift_o      = shift_i | hit_q;
  assign empty_seen_o = empty_seen_i | is_empty;

  always_comb begin
    code_d = code_q;
    if (ctl_i.rel && ctl_i.any_hit && shift_o) begin
      code_d = next_code_i;
    end else if (ctl_i.press && !ctl_i.any_hit && is_empty && !empty_seen_i) begin
      code_d = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (ctl_i.cmp) begin
        // empty slots hold zero and a zero key never reaches press or release
        hit_q <= (code_q == key_i);
      end
      if (ctl_i.commit) begin
        code_q <= code_d;
      end
    end
  end

  assign code_o   = code_q;
  assign code_d_o = code_d;

endmodule

@@ design/hid_keyboard_report_tracker_top.sv @@
// hid_keyboard_report_tracker_top: keyboard report tracker with a chain of slot cells
// depends on hkrt_pkg, hkrt_if.sv (channels) and hkrt_cell
//
// usage
//   evt_i carries one key event per word: mode (down, up, no-op) and keycode.
//   rpt_o returns one word per event: modifier byte, six slot codes and the
//   number of held keys, all taken after the event has been applied.
//   codes 0xE0..0xE7 set or clear a modifier bit; other non-zero codes are
//   appended to the first empty slot on press (ignored if held or full) and
//   removed on release, with the later slots moving down one place.
// timing
//   an event passes through a compare cycle in which every slot cell
//   latches whether it holds the key, then an update cycle in which the cells
//   shift or append and the report register is loaded. a new event can be
//   accepted in the update cycle, once the report register is free.
// reset
//   rst_ni clears the modifier byte, all slots, the count, the sequencer and
//   the report valid.
// stall
//   while rpt_o is stalled one further event is accepted and compared; it then
//   waits in the update cycle until the pending report is taken.
module hid_keyboard_report_tracker_top #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hkrt_evt_if.sink   evt_i,
  hkrt_rpt_if.source rpt_o
);
  import hkrt_pkg::*;

  localparam int unsigned CNT_W = $clog2(KEY_SLOTS + 1);

  // one-hot sequencer
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e st_q, st_d;

  logic [MODE_W-1:0] mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  mod_q, mod_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q;
  logic              accept, commit;
  logic              is_mod, is_zero, full;
  hkrt_ctl_t         ctl;

  // cell chain wiring
  logic [KEY_W-1:0] code    [KEY_SLOTS];
  logic [KEY_W-1:0] code_d  [KEY_SLOTS];
  logic [KEY_W-1:0] next_code [KEY_SLOTS];
  logic [KEY_SLOTS:0] shift_c;
  logic [KEY_SLOTS:0] empty_c;

  // report register
  logic [KEY_W-1:0]  rpt_mod_q;
  logic [KEY_W-1:0]  rpt_slot_q [REPORT_SLOTS];
  logic [HELD_W-1:0] rpt_held_q;
  logic [CNT_W+3:0]  cnt_ext;
  logic [HELD_W-1:0] held_d;

  assign commit      = (st_q == ST_UPD) && (!out_valid_q || rpt_o.ready);
  assign evt_i.ready = (st_q == ST_IDLE) || commit;
  assign accept      = evt_i.valid && evt_i.ready;

  assign is_mod  = ((key_q & MOD_MASK) == MOD_BASE);
  assign is_zero = (key_q == '0);
  assign full    = (cnt_q == CNT_W'(KEY_SLOTS));

  assign ctl.cmp     = (st_q == ST_CMP);
  assign ctl.commit  = commit;
  assign ctl.press   = (mode_q == MODE_DOWN) && !is_mod && !is_zero;
  assign ctl.rel     = (mode_q == MODE_UP) && !is_mod && !is_zero;
  assign ctl.any_hit = shift_c[KEY_SLOTS];

  assign shift_c[0] = 1'b0;
  assign empty_c[0] = 1'b0;

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
    // the top cell refills with an empty slot on release
    if (i == KEY_SLOTS - 1) begin : g_last
      assign next_code[i] = '0;
    end else begin : g_mid
      assign next_code[i] = code[i+1];
    end
    hkrt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (key_q),
      .next_code_i  (next_code[i]),
      .shift_i      (shift_c[i]),
      .empty_seen_i (empty_c[i]),
      .code_o       (code[i]),
      .code_d_o     (code_d[i]),
      .shift_o      (shift_c[i+1]),
      .empty_seen_o (empty_c[i+1])
    );
  end

  // sequencer next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (accept) st_d = ST_CMP;
      ST_CMP:  st_d = ST_UPD;
      ST_UPD: begin
        if (commit) st_d = accept ? ST_CMP : ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // modifier byte and held count
  always_comb begin
    mod_d = mod_q;
    cnt_d = cnt_q;
    if (is_mod) begin
      if (mode_q == MODE_DOWN) begin
        mod_d = mod_q | (KEY_W'(1) << key_q[2:0]);
      end else if (mode_q == MODE_UP) begin
        mod_d = mod_q & ~(KEY_W'(1) << key_q[2:0]);
      end
    end
    if (ctl.rel && ctl.any_hit && (cnt_q != '0)) begin
      cnt_d = cnt_q - CNT_W'(1);
    end else if (ctl.press && !ctl.any_hit && !full) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // held_count saturates at seven for long slot lists
  assign cnt_ext = (CNT_W+4)'(cnt_d);
  assign held_d  = (cnt_ext > (CNT_W+4)'(7)) ? HELD_W'(7) : cnt_ext[HELD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      mod_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (commit) begin
        mod_q <= mod_d;
        cnt_q <= cnt_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (rpt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // event and report words
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= evt_i.mode;
      key_q  <= evt_i.keycode;
    end
    if (commit) begin
      rpt_mod_q  <= mod_d;
      rpt_held_q <= held_d;
      for (int j = 0; j < REPORT_SLOTS; j++) begin
        rpt_slot_q[j] <= (j < KEY_SLOTS) ? code_d[j] : '0;
      end
    end
  end

  assign rpt_o.valid         = out_valid_q;
  assign rpt_o.modifier_bits = rpt_mod_q;
  assign rpt_o.slot0_code    = rpt_slot_q[0];
  assign rpt_o.slot1_code    = rpt_slot_q[1];
  assign rpt_o.slot2_code    = rpt_slot_q[2];
  assign rpt_o.slot3_code    = rpt_slot_q[3];
  assign rpt_o.slot4_code    = rpt_slot_q[4];
  assign rpt_o.slot5_code    = rpt_slot_q[5];
  assign rpt_o.held_count    = rpt_held_q;

  // held count never exceeds the slot list
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(KEY_SLOTS))
    else $error("held count beyond slot list");

  // compare is always followed by update
  a_cmp_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CMP) |=> (st_q == ST_UPD))
    else $error("compare not followed by update");

  // every update leaves a report pending
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("report lost after update");

  // no update while an untaken report is pending
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rpt_o.ready) |-> !commit)
    else $error("report overwritten");

endmodule
